// ===== hw/rtl/rsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_pkg: shared constants for the ReLU / softmax activation unit
// Holds vector length limits, field widths and the exp factor table.
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int DATA_W  = 16;
  localparam int EXP_W   = 17;   // exp value in Q0.16, 0..65536
  localparam int SUM_W   = EXP_W + CNT_W - 1;
  localparam int NUM_W   = EXP_W + 17;
  localparam int EXP_STEPS = 16;

  typedef logic [31:0] factor_tbl_t [EXP_STEPS];

  // Q0.32 factors exp(-2^(b-10)); each one is the rounded square of the last.
  function automatic factor_tbl_t exp_factors();
    factor_tbl_t tbl;
    logic [63:0] f;
    f = 64'd4290775039;
    for (int b = 0; b < EXP_STEPS; b++) begin
      tbl[b] = f[31:0];
      f = (f * f + 64'h8000_0000) >> 32;
    end
    return tbl;
  endfunction

  localparam factor_tbl_t EXP_FACTOR = exp_factors();

endpackage

// ===== hw/rtl/relu_softmax_activation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relu_softmax_activation: vector ReLU / softmax activation unit
// Element stream in, activation stream out, with a mode register.
// ----------------------------------------------------------------------------
// Usage:
//   Elements (signed Q5.10) arrive on the s_ stream, tlast marking the last
//   element of a vector. Results leave on the m_ stream: tdata is the value,
//   tlast marks the final result of a vector and tuser flags a truncated one.
//   The cfg channel writes the mode bit (0 ReLU, 1 softmax); it is accepted
//   only while the block is idle and discards any partly received vector.
//   While a cfg write is offered, the s_ stream is held off.
//   In ReLU mode each transfer yields one result in the next cycle, one element
//   per cycle while the receiver keeps up.
//   In softmax mode elements are stored in a 64-entry RAM at one per cycle.
//   After the last element an exp pass (16-step iterative multiplier) runs over
//   every stored element, then a division pass (34-step restoring divider)
//   yields the results in order. Elements past 64 are dropped and set tuser.
//   Reset (synchronous, active high) selects ReLU mode and clears the vector
//   state; no RAM clearing pass is needed. When the receiver stalls, the output
//   register holds its result and in ReLU mode the input side stops accepting.
// ----------------------------------------------------------------------------
module relu_softmax_activation (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] element
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] result
  output logic        m_tlast,
  output logic        m_tuser,   // [0] truncated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam int AW = rsa_pkg::ADDR_W;
  localparam int CW = rsa_pkg::CNT_W;

  typedef enum logic [3:0] {
    IDLE, SUM_RD, SUM_GO, SUM_WAIT, DIV_RD, DIV_GO, DIV_WAIT, PUSH
  } state_t;

  state_t                    state;
  logic                      mode;
  logic [CW-1:0]             count;
  logic signed [15:0]        run_max;
  logic                      ovf;
  logic [CW-1:0]             idx;
  logic [rsa_pkg::SUM_W-1:0] sum;

  logic                      in_xfer;
  logic                      out_free;
  logic                      out_load;
  logic                      el_wr;
  logic [15:0]               el_rd;
  logic                      exp_start;
  logic                      exp_done;
  logic [rsa_pkg::EXP_W-1:0] exp_e;
  logic [rsa_pkg::EXP_W-1:0] e_rd;
  logic                      div_start;
  logic                      div_done;
  logic [15:0]               div_p;
  logic                      last_idx;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == IDLE) && !cfg_valid && (mode || out_free);
  assign cfg_ready = (state == IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign el_wr     = in_xfer && mode && (count != CW'(rsa_pkg::MAX_LEN));
  assign exp_start = (state == SUM_GO);
  assign div_start = (state == DIV_GO);
  assign last_idx  = (idx + 1'b1) == count;
  // The output register takes a new result in this cycle.
  assign out_load  = ((state == IDLE) && in_xfer && !mode) ||
                     ((state == PUSH) && out_free);

  // Element store, written while loading, read during the exp pass.
  rsa_ram #(.DEPTH(rsa_pkg::MAX_LEN), .WIDTH(16)) u_el_ram (
    .clk     (clk),
    .wr_en   (el_wr),
    .wr_addr (count[AW-1:0]),
    .wr_data (s_tdata),
    .rd_en   (state == SUM_RD),
    .rd_addr (idx[AW-1:0]),
    .rd_data (el_rd)
  );

  // Exp store, written by the exp pass, read during the division pass.
  rsa_ram #(.DEPTH(rsa_pkg::MAX_LEN), .WIDTH(rsa_pkg::EXP_W)) u_exp_ram (
    .clk     (clk),
    .wr_en   ((state == SUM_WAIT) && exp_done),
    .wr_addr (idx[AW-1:0]),
    .wr_data (exp_e),
    .rd_en   (state == DIV_RD),
    .rd_addr (idx[AW-1:0]),
    .rd_data (e_rd)
  );

  rsa_exp u_exp (
    .clk   (clk),
    .rst   (rst),
    .start (exp_start),
    .t     (16'(run_max - $signed(el_rd))),
    .done  (exp_done),
    .e     (exp_e)
  );

  rsa_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .e     (e_rd),
    .sum   (sum),
    .done  (div_done),
    .p     (div_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      mode     <= 1'b0;
      count    <= '0;
      run_max  <= 16'sh8000;
      ovf      <= 1'b0;
      idx      <= '0;
      sum      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cfg_valid && cfg_ready) begin
            mode    <= cfg_data;
            count   <= '0;
            run_max <= 16'sh8000;
            ovf     <= 1'b0;
          end else if (in_xfer) begin
            if (!mode) begin
              m_tvalid <= 1'b1;
              m_tdata  <= s_tdata[15] ? 16'h0 : s_tdata;
              m_tlast  <= s_tlast;
              m_tuser  <= 1'b0;
            end else begin
              if (el_wr) begin
                count <= count + 1'b1;
                if ($signed(s_tdata) > run_max) begin
                  run_max <= $signed(s_tdata);
                end
              end else begin
                ovf <= 1'b1;
              end
              if (s_tlast) begin
                idx   <= '0;
                sum   <= '0;
                state <= SUM_RD;
              end
            end
          end
        end
        SUM_RD:   state <= SUM_GO;
        SUM_GO:   state <= SUM_WAIT;
        SUM_WAIT: begin
          if (exp_done) begin
            sum <= sum + rsa_pkg::SUM_W'(exp_e);
            if (last_idx) begin
              idx   <= '0;
              state <= DIV_RD;
            end else begin
              idx   <= idx + 1'b1;
              state <= SUM_RD;
            end
          end
        end
        DIV_RD:   state <= DIV_GO;
        DIV_GO:   state <= DIV_WAIT;
        DIV_WAIT: begin
          if (div_done) begin
            state <= PUSH;
          end
        end
        PUSH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= div_p;
            m_tlast  <= last_idx;
            m_tuser  <= ovf;
            idx      <= idx + 1'b1;
            if (last_idx) begin
              count   <= '0;
              run_max <= 16'sh8000;
              ovf     <= 1'b0;
              state   <= IDLE;
            end else begin
              state <= DIV_RD;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // The element count never exceeds the buffer depth.
  assert property (@(posedge clk) disable iff (rst)
    count <= CW'(rsa_pkg::MAX_LEN))
    else $error("element count exceeds buffer depth");

  // A softmax pass only starts with at least one stored element.
  assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |-> (count != '0) && (idx < count))
    else $error("softmax pass index out of range");

  // A pending result is never overwritten before it is taken.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output register overwritten while stalled");
`endif

endmodule

// ===== hw/rtl/rsa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_ram: simple dual-port synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rsa_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/rsa_exp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_exp: iterative exp(-t) unit
// One bit of t per cycle, one 32x32 multiply per step, result in Q0.16.
// ----------------------------------------------------------------------------
module rsa_exp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [15:0]               t,
  output logic                      done,
  output logic [rsa_pkg::EXP_W-1:0] e
);

  logic [32:0] acc;
  logic [15:0] t_reg;
  logic [3:0]  step;
  logic        busy;
  logic [63:0] prod;
  logic [32:0] acc_next;
  logic [33:0] e_wide;

  always_comb begin
    prod = 64'(acc[31:0]) * 64'(rsa_pkg::EXP_FACTOR[step]);
    acc_next = acc;
    if (t_reg[step]) begin
      if (acc[32]) begin
        acc_next = {1'b0, rsa_pkg::EXP_FACTOR[step]};
      end else begin
        acc_next = 33'((prod + 64'h8000_0000) >> 32);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        step  <= '0;
        acc   <= 33'h1_0000_0000;
        t_reg <= t;
      end else if (busy) begin
        acc  <= acc_next;
        step <= step + 4'd1;
        if (step == 4'(rsa_pkg::EXP_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign e_wide = {1'b0, acc} + 34'h8000;
  assign e      = e_wide[16 +: rsa_pkg::EXP_W];

endmodule

// ===== hw/rtl/rsa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_div: restoring divider for the softmax normalization
// Rounds e/sum into Q0.16 one quotient bit per cycle, saturated at 65535.
// ----------------------------------------------------------------------------
module rsa_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rsa_pkg::EXP_W-1:0] e,
  input  logic [rsa_pkg::SUM_W-1:0] sum,
  output logic                      done,
  output logic [15:0]               p
);

  localparam int NW = rsa_pkg::NUM_W;
  localparam int SW = rsa_pkg::SUM_W;

  logic [NW-1:0]       num;
  logic [NW-1:0]       quo;
  logic [SW-1:0]       rem;
  logic [SW-1:0]       den;
  logic [$clog2(NW):0] cnt;
  logic                busy;
  logic [SW:0]         rem_s;
  logic                fits;

  assign rem_s = {rem, num[NW-1]};
  assign fits  = rem_s >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        den  <= sum;
        rem  <= '0;
        quo  <= '0;
        num  <= NW'({e, 16'b0}) + NW'(sum >> 1);
      end else if (busy) begin
        num <= {num[NW-2:0], 1'b0};
        quo <= {quo[NW-2:0], fits};
        rem <= fits ? SW'(rem_s - {1'b0, den}) : rem_s[SW-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(NW)+1)'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign p = (|quo[NW-1:16]) ? 16'hFFFF : quo[15:0];

endmodule

// ===== verif/tb_relu_softmax_activation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_relu_softmax_activation: self-checking bench for the activation unit
// Streams elements through the block in ReLU and softmax modes, predicts
// every result with an independent fixed-point model and compares each
// output transfer field by field. Sender bursts and receiver stalls are
// randomized; the mode register is written between idle phases.
// ----------------------------------------------------------------------------
module tb_relu_softmax_activation;

  typedef struct packed {
    logic [15:0] element;
    logic        last;
  } elem_t;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
    logic        trunc;
  } prob_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  relu_softmax_activation i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Elements waiting to be sent, and probabilities/values still owed by the DUT.
  elem_t pending_elems[$];
  prob_t owed_results[$];
  int    errors = 0;
  int    cycles = 0;
  int    n_results = 0;
  int    n_vectors = 0;
  localparam int CYCLE_LIMIT = 1500000;

  // Predictor state: mode and the partly received softmax vector.
  logic        pred_mode;
  logic signed [15:0] vec_buf [rsa_pkg::MAX_LEN];
  int          vec_count;
  logic signed [15:0] vec_max;
  logic        vec_over;

  function automatic logic [31:0] exp_q16(logic [15:0] t);
    logic [63:0] acc;
    logic [63:0] f;
    acc = 64'd1 << 32;
    f = 64'd4290775039;
    for (int b = 0; b < 16; b++) begin
      if (t[b]) acc = (acc * f + 64'h8000_0000) >> 32;
      f = (f * f + 64'h8000_0000) >> 32;
    end
    return 32'((acc + 64'h8000) >> 16);
  endfunction

  task automatic clear_vector();
    vec_count = 0;
    vec_max = -16'sd32768;
    vec_over = 1'b0;
  endtask

  // Works out what one accepted element produces and queues it.
  task automatic predict_activation(elem_t it);
    logic [31:0] e [rsa_pkg::MAX_LEN];
    logic [63:0] sum;
    logic [63:0] p;
    logic [15:0] t;
    prob_t r;
    sum = '0;
    if (!pred_mode) begin
      r.value = it.element[15] ? 16'd0 : it.element;
      r.last = it.last;
      r.trunc = 1'b0;
      owed_results.push_back(r);
      return;
    end
    if (vec_count < rsa_pkg::MAX_LEN) begin
      vec_buf[vec_count] = it.element;
      vec_count++;
      if ($signed(it.element) > vec_max) vec_max = it.element;
    end else begin
      vec_over = 1'b1;
    end
    if (!it.last) return;
    for (int i = 0; i < vec_count; i++) begin
      t = 16'(vec_max - vec_buf[i]);
      e[i] = exp_q16(t);
      sum += e[i];
    end
    for (int i = 0; i < vec_count; i++) begin
      p = 0;
      if (sum != 0) p = ((64'(e[i]) << 16) + (sum >> 1)) / sum;
      if (p > 65535) p = 65535;
      r.value = p[15:0];
      r.last = (i + 1 == vec_count);
      r.trunc = vec_over;
      owed_results.push_back(r);
    end
    clear_vector();
  endtask

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    elem_t nx;
    if (!rst) begin
      if (s_tvalid && s_tready) predict_activation('{s_tdata, s_tlast});
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_elems.size() > 0) begin
          nx = pending_elems.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nx.element;
          s_tlast <= nx.last;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls follow their own pattern, with stall-free stretches.
  int stall_phase = 0;
  always @(posedge clk) begin
    prob_t want;
    cycles <= cycles + 1;
    stall_phase <= stall_phase + 1;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        n_results <= n_results + 1;
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result data=%h last=%b user=%b",
                   $time, m_tdata, m_tlast, m_tuser);
          errors++;
        end else begin
          want = owed_results.pop_front();
          if (m_tdata !== want.value) begin
            $display("%0t: result expected %h actual %h", $time, want.value, m_tdata);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t: result_last expected %b actual %b", $time, want.last, m_tlast);
            errors++;
          end
          if (m_tuser !== want.trunc) begin
            $display("%0t: truncated expected %b actual %b", $time, want.trunc, m_tuser);
            errors++;
          end
        end
      end
      if (stall_phase[9]) m_tready <= 1'b1;
      else m_tready <= ($urandom_range(0, 3) != 0);
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d results still owed", owed_results.size());
      $display("tb_relu_softmax_activation: done, errors");
      $finish;
    end
  end

  task automatic push_elem(logic [15:0] v, logic last);
    pending_elems.push_back('{v, last});
  endtask

  // Random vector of the given length; elements are fully random or near a shared base.
  task automatic push_vector(int len);
    logic [15:0] base;
    base = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 1)) push_elem(16'($urandom), i == len - 1);
      else push_elem(base + 16'($urandom_range(0, 8191)) - 16'd4096, i == len - 1);
    end
    n_vectors++;
  endtask

  // Waits until the block has delivered everything and is quiet.
  task automatic drain();
    wait (pending_elems.size() == 0 && !s_tvalid && owed_results.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pred_mode = m;
    clear_vector();
  endtask

  initial begin
    int left;
    int len;
    pred_mode = 1'b0;
    clear_vector();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // The mode write from reset value, then ReLU extremes.
    write_mode(1'b0);
    push_elem(16'h0000, 1'b0); push_elem(16'h7FFF, 1'b0); push_elem(16'h8000, 1'b0);
    push_elem(16'hFFFF, 1'b0); push_elem(16'h0001, 1'b1); push_elem(16'h5555, 1'b0);
    push_elem(16'hAAAA, 1'b1);
    drain();

    // Softmax: single element, equal pair, widest spread, an overlong and a full-length vector.
    write_mode(1'b1);
    push_elem(16'h1234, 1'b1);
    push_elem(16'h7FFF, 1'b0); push_elem(16'h7FFF, 1'b1);
    push_elem(16'h7FFF, 1'b0); push_elem(16'h8000, 1'b0); push_elem(16'h0000, 1'b1);
    push_vector(rsa_pkg::MAX_LEN + 3);
    push_vector(rsa_pkg::MAX_LEN);
    drain();

    // A partial vector thrown away by a mode write.
    push_elem(16'h0400, 1'b0); push_elem(16'h0800, 1'b0);
    drain();
    write_mode(1'b1);
    push_elem(16'h0C00, 1'b1);
    drain();

    // Random phases alternating the mode.
    left = 130;
    while (left > 0) begin
      write_mode(1'($urandom_range(0, 1)));
      for (int k = 0; k < 6 && left > 0; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          len = $urandom_range(rsa_pkg::MAX_LEN - 1, rsa_pkg::MAX_LEN + 4);
        end else begin
          len = $urandom_range(1, 8);
        end
        push_vector(len);
        left -= len;
      end
      drain();
    end
    write_mode(1'b0);
    drain();

    $display("Covered %0d vectors and %0d checked results in ReLU and softmax modes,",
             n_vectors, n_results);
    $display("including overlong vectors and a discarded partial vector.");
    if (errors == 0) begin
      $display("tb_relu_softmax_activation: done, clean");
    end else begin
      $display("tb_relu_softmax_activation: done, errors");
    end
    $finish;
  end

endmodule
